// ===== src/esc_pkg.sv =====
// Shared constants and types for the edge set with connectivity check.
`timescale 1ns / 1ps
package esc_pkg;
  localparam int MAX_NODES  = 64;
  localparam int NODE_W     = $clog2(MAX_NODES);
  localparam int CNT_W      = 8;
  localparam int NCOUNT_W   = 7;
  localparam int ECOUNT_W   = 13;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_DEL   = 3'd1;
  localparam logic [2:0] CMD_NODE  = 3'd2;
  localparam logic [2:0] CMD_EDGE  = 3'd3;
  localparam logic [2:0] CMD_CONN  = 3'd4;

  // Control from the sequencer to the reachability sweep unit
  typedef struct packed {
    logic              start;  // clear reached set and change flag
    logic              pass;   // clear change flag for another pass
    logic              step;   // fold in one adjacency row
    logic [NODE_W-1:0] idx;    // row number being folded
  } sweep_ctl_t;
endpackage

// ===== src/esc_ram.sv =====
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module esc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ===== src/esc_sweep.sv =====
// Reachability sweep unit: grows a reached node set one adjacency row at a time.
`timescale 1ns / 1ps
module esc_sweep import esc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sweep_ctl_t           ctl,
  input  logic [MAX_NODES-1:0] row,
  input  logic [MAX_NODES-1:0] present,
  output logic                 changed,
  output logic                 connected
);
  logic [MAX_NODES-1:0] reached_r, reached_nxt, idx_bit;
  logic                 changed_r, seed, cur;

  // Seed the set with the first present node met in the first pass
  always_comb begin
    idx_bit     = '0;
    idx_bit[ctl.idx] = 1'b1;
    seed        = (reached_r == '0) && present[ctl.idx];
    cur         = reached_r[ctl.idx] || seed;
    reached_nxt = reached_r;
    if (cur) begin
      reached_nxt = reached_nxt | row | idx_bit;
    end
    if ((row & reached_r) != '0) begin
      reached_nxt = reached_nxt | idx_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reached_r <= '0;
      changed_r <= 1'b0;
    end else if (ctl.start) begin
      reached_r <= '0;
      changed_r <= 1'b0;
    end else if (ctl.pass) begin
      changed_r <= 1'b0;
    end else if (ctl.step) begin
      reached_r <= reached_nxt;
      if (reached_nxt != reached_r) begin
        changed_r <= 1'b1;
      end
    end
  end

  assign changed   = changed_r;
  assign connected = (present & ~reached_r) == '0;
endmodule

// ===== src/edge_set_with_connectivity_check_core.sv =====
// Top level: edge set with incidence counts and connectivity test.
`timescale 1ns / 1ps
// One command per input beat, one result beat per command.
// An add or remove that changes the set steps through the adjacency row read,
// the source count update, then the destination count read and update, then
// the result. A duplicate add, a missing remove and an edge test go from the
// row read straight to the result. A node test and an unused command code go
// straight to the result.
// A connectivity test on a nonempty set sweeps all 64 adjacency rows through
// the single row read port. Each row is read, then folded in, and a closing
// step ends the sweep. Sweeps repeat until one leaves the reached set
// unchanged: at least two sweeps, at most one more than the number of present
// nodes. On an empty set the test goes straight to the result.
// A previous result that is still waiting on the output holds the block in its
// result state. The block takes a new command only when idle.
module edge_set_with_connectivity_check_core import esc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // command[2:0], src_node[8:3], dst_node[14:9], query_node[20:15], zero fill
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // answer[0], node_count[7:1], edge_count[20:8], last_src[26:21],
  // last_dst[32:27], zero fill
  output logic [OUT_DATA_W-1:0] out_tdata
);
  typedef enum logic [2:0] {
    S_IDLE, S_ROW, S_CNTD_RD, S_CNTD, S_CONN_RD, S_CONN_USE, S_CONN_END, S_DONE
  } state_t;

  state_t               state_r;
  logic [2:0]           cmd_r;
  logic [NODE_W-1:0]    src_r, dst_r, idx_r, adj_ra_r, cnt_ra_r;
  logic [MAX_NODES-1:0] row_vld_r, cnt_vld_r, present_r;
  logic [NCOUNT_W-1:0]  node_cnt_r;
  logic [ECOUNT_W-1:0]  edge_cnt_r;
  logic [NODE_W-1:0]    last_src_r, last_dst_r;
  logic                 ans_r, out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic [2:0]           in_cmd;
  logic [NODE_W-1:0]    in_src, in_dst, in_qry, adj_raddr, cnt_raddr, cnt_waddr;
  logic [MAX_NODES-1:0] adj_rdata, adj_row, dst_bit;
  logic [CNT_W-1:0]     cnt_rdata, cnt_val, cnt_wdata;
  logic                 adj_we, cnt_we, hit, do_add, do_del, in_acc;
  logic                 sw_changed, sw_connected;
  sweep_ctl_t           sw_ctl;

  assign in_cmd = in_tdata[2:0];
  assign in_src = in_tdata[8:3];
  assign in_dst = in_tdata[14:9];
  assign in_qry = in_tdata[20:15];
  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  // Read ports: rows and counts read as zero until first written
  assign adj_raddr = (state_r == S_CONN_RD) ? idx_r : in_src;
  assign cnt_raddr = (state_r == S_CNTD_RD) ? dst_r : in_src;
  assign adj_row   = row_vld_r[adj_ra_r] ? adj_rdata : '0;
  assign cnt_val   = cnt_vld_r[cnt_ra_r] ? cnt_rdata : '0;

  always_comb begin
    dst_bit = '0;
    dst_bit[dst_r] = 1'b1;
  end
  assign hit    = adj_row[dst_r];
  assign do_add = (cmd_r == CMD_ADD) && !hit;
  assign do_del = (cmd_r == CMD_DEL) && hit;

  // Write ports: flip the edge bit, step the count of source then destination
  assign adj_we    = (state_r == S_ROW) && (do_add || do_del);
  assign cnt_we    = adj_we || (state_r == S_CNTD);
  assign cnt_waddr = (state_r == S_CNTD) ? dst_r : src_r;
  assign cnt_wdata = (cmd_r == CMD_ADD) ? cnt_val + 1'b1 : cnt_val - 1'b1;

  esc_ram #(.WIDTH(MAX_NODES), .DEPTH(MAX_NODES)) u_adj (
    .clk(clk), .we(adj_we), .waddr(src_r), .wdata(adj_row ^ dst_bit),
    .raddr(adj_raddr), .rdata(adj_rdata)
  );

  esc_ram #(.WIDTH(CNT_W), .DEPTH(MAX_NODES)) u_cnt (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rdata)
  );

  always_comb begin
    sw_ctl       = '0;
    sw_ctl.start = in_acc && (in_cmd == CMD_CONN);
    sw_ctl.pass  = (state_r == S_CONN_END) && sw_changed;
    sw_ctl.step  = (state_r == S_CONN_USE);
    sw_ctl.idx   = adj_ra_r;
  end

  esc_sweep u_sweep (
    .clk(clk), .rst_n(rst_n), .ctl(sw_ctl), .row(adj_row), .present(present_r),
    .changed(sw_changed), .connected(sw_connected)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    adj_ra_r <= adj_raddr;
    cnt_ra_r <= cnt_raddr;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      row_vld_r   <= '0;
      cnt_vld_r   <= '0;
      present_r   <= '0;
      node_cnt_r  <= '0;
      edge_cnt_r  <= '0;
      last_src_r  <= '0;
      last_dst_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_cmd;
            src_r <= in_src;
            dst_r <= in_dst;
            idx_r <= '0;
            ans_r <= 1'b0;
            case (in_cmd)
              CMD_ADD, CMD_DEL, CMD_EDGE: state_r <= S_ROW;
              CMD_NODE: begin
                ans_r   <= present_r[in_qry];
                state_r <= S_DONE;
              end
              CMD_CONN: begin
                if (edge_cnt_r == '0) begin
                  ans_r   <= 1'b1;
                  state_r <= S_DONE;
                end else begin
                  state_r <= S_CONN_RD;
                end
              end
              default: state_r <= S_DONE;
            endcase
          end
        end
        S_ROW: begin
          state_r <= (do_add || do_del) ? S_CNTD_RD : S_DONE;
          if (cmd_r == CMD_EDGE) begin
            ans_r <= hit;
          end
          if (do_add) begin
            row_vld_r[src_r] <= 1'b1;
            cnt_vld_r[src_r] <= 1'b1;
            present_r[src_r] <= 1'b1;
            edge_cnt_r <= edge_cnt_r + 1'b1;
            if (cnt_val == '0) begin
              node_cnt_r <= node_cnt_r + 1'b1;
            end
            last_src_r <= src_r;
            last_dst_r <= dst_r;
            ans_r      <= 1'b1;
          end
          if (do_del) begin
            edge_cnt_r <= edge_cnt_r - 1'b1;
            if (cnt_val == CNT_W'(1)) begin
              present_r[src_r] <= 1'b0;
              node_cnt_r <= node_cnt_r - 1'b1;
            end
            ans_r   <= 1'b1;
          end
        end
        S_CNTD_RD: state_r <= S_CNTD;
        S_CNTD: begin
          cnt_vld_r[dst_r] <= 1'b1;
          if (cmd_r == CMD_ADD) begin
            present_r[dst_r] <= 1'b1;
            if (cnt_val == '0) begin
              node_cnt_r <= node_cnt_r + 1'b1;
            end
          end else if (cnt_val == CNT_W'(1)) begin
            present_r[dst_r] <= 1'b0;
            node_cnt_r <= node_cnt_r - 1'b1;
          end
          state_r <= S_DONE;
        end
        S_CONN_RD: state_r <= S_CONN_USE;
        S_CONN_USE: begin
          if (idx_r == NODE_W'(MAX_NODES - 1)) begin
            state_r <= S_CONN_END;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_CONN_RD;
          end
        end
        S_CONN_END: begin
          idx_r <= '0;
          if (sw_changed) begin
            state_r <= S_CONN_RD;
          end else begin
            ans_r   <= sw_connected;
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {7'd0, last_dst_r, last_src_r, edge_cnt_r, node_cnt_r, ans_r};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Checks
  a_node_bound: assert property (@(posedge clk) disable iff (!rst_n)
    node_cnt_r <= NCOUNT_W'(MAX_NODES)) else $error("node count overflow");
  a_empty_nodes: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_IDLE) && (edge_cnt_r == '0)) |-> (node_cnt_r == '0))
    else $error("nodes without edges");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready) else $error("accepted two beats back to back");
  a_present_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> ($countones(present_r) == node_cnt_r))
    else $error("present mask and node count disagree");
endmodule
